// ===== rtl/dcpf_pkg.sv =====
// dithered column page fill: shared types and constants
// no dependencies
`timescale 1ns / 1ps

package dcpf_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SCREEN_ROWS     = 2'd0,
    REG_SCREEN_COLUMNS  = 2'd1,
    REG_DITHER_PATTERNS = 2'd2
  } cfg_reg_e;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned ROWS_W      = 9;
  localparam int unsigned COLS_W      = 9;
  localparam int unsigned X_W         = 8;
  localparam int unsigned H_W         = 16;
  localparam int unsigned ADDR_W      = 13;
  localparam int unsigned ROW_IDX_W   = 10;
  localparam int unsigned IDX_W       = 3;

  localparam logic [ROWS_W-1:0]     ROWS_RESET   = 9'd64;
  localparam logic [COLS_W-1:0]     COLS_RESET   = 9'd128;
  localparam logic [CFG_DATA_W-1:0] DITHER_RESET = '0;
  localparam logic [IDX_W-1:0]      PHASE_STEP   = 3'd5;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

endpackage

// ===== rtl/dcpf_div.sv =====
// dithered column page fill: compare-subtract unit for the dither index
// produces min(floor(4*dividend/divisor), 7), one quotient bit per cycle; uses dcpf_pkg
`timescale 1ns / 1ps

module dcpf_div #(
  parameter int unsigned DW = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [DW-1:0]                dividend_i,
  input  logic [DW-1:0]                divisor_i,
  output logic                         done_o,
  output logic [dcpf_pkg::IDX_W-1:0]   quot_o
);

  logic [DW-1:0]              rem_q, rem_d;
  logic [DW-1:0]              dv_q, dv_d;
  logic [dcpf_pkg::IDX_W-1:0] quot_q, quot_d;
  logic [1:0]                 cnt_q, cnt_d;
  logic                       run_q, run_d;
  logic                       done_q, done_d;
  logic                       ge;

  assign ge = (rem_q >= dv_q);

  always_comb begin
    rem_d  = rem_q;
    dv_d   = dv_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i;
      dv_d   = divisor_i;
      quot_d = '0;
      cnt_d  = 2'd2;
      run_d  = 1'b1;
    end else if (run_q) begin
      if (ge) begin
        rem_d = rem_q - dv_q;
      end
      quot_d = {quot_q[dcpf_pkg::IDX_W-2:0], ge};
      dv_d   = dv_q >> 1;
      cnt_d  = cnt_q - 2'd1;
      if (cnt_q == 2'd0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dv_q   <= dv_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/dithered_column_page_fill.sv =====
// dithered column page fill: top level, sequencer, run ends and page emitter
// uses dcpf_pkg and dcpf_div
`timescale 1ns / 1ps

// Draws one dithered screen column per input beat into a page-organized buffer.
// Input channel s_axis: one beat per column, carrying the column index and the
// wall height (unsigned fixed point). Output channel m_axis: one beat per 8-row
// page, from page 0 upward, with the buffer address, the masked pixel byte and
// tlast on the final page of the column. A screen under 8 rows gives no beats.
// Configuration: cfg_we_i writes register cfg_index_i (0 rows, 1 columns,
// 2 dither bytes) with cfg_wdata_i; write only while the block is idle.
// Timing: s_axis_tready is high only between columns. After a beat is taken the
// compare-subtract unit works out the dither index and the mask, then one page
// beat leaves per cycle while m_axis is not stalled. The sequencer then returns
// to idle, where it takes the next column.
// The result register holds its beat while m_axis_tready is low and the page
// sequencer waits; the last beat of a column may still wait while the next
// column is accepted.
// Reset: registers take their reset values (64 rows, 128 columns, dither bytes
// zero), the dither phase returns to zero and no output beat is pending.

module dithered_column_page_fill #(
  parameter int unsigned MAX_PAGES        = 32,
  parameter int unsigned MAX_COLUMNS      = 256,
  parameter int unsigned HEIGHT_FRAC_BITS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic                              cfg_we_i,
  input  logic [dcpf_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [dcpf_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // column beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // column_x[7:0], wall_height[23:8]
  // page beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // buffer_address[12:0], pixel_byte[20:13], zero[23:21]
  output logic        m_axis_tlast    // last_byte
);

  localparam int unsigned F     = HEIGHT_FRAC_BITS;
  localparam int unsigned FW    = dcpf_pkg::ROWS_W + F;
  localparam int unsigned CMPW  = (FW > dcpf_pkg::H_W) ? FW : dcpf_pkg::H_W;
  localparam int unsigned DW    = ((FW + 2 > dcpf_pkg::H_W + 3) ? FW + 2 : dcpf_pkg::H_W + 3) + 1;
  localparam int unsigned YW    = 18 + F;
  localparam int unsigned PGW   = $clog2(MAX_PAGES + 1);
  localparam int unsigned RPW   = dcpf_pkg::ROWS_W - 3;

  // configuration registers
  logic [dcpf_pkg::ROWS_W-1:0]     rows_q;
  logic [dcpf_pkg::COLS_W-1:0]     cols_q;
  logic [dcpf_pkg::CFG_DATA_W-1:0] dither_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q   <= dcpf_pkg::ROWS_RESET;
      cols_q   <= dcpf_pkg::COLS_RESET;
      dither_q <= dcpf_pkg::DITHER_RESET;
    end else if (cfg_we_i) begin
      case (dcpf_pkg::cfg_reg_e'(cfg_index_i))
        dcpf_pkg::REG_SCREEN_ROWS:     rows_q   <= cfg_wdata_i[dcpf_pkg::ROWS_W-1:0];
        dcpf_pkg::REG_SCREEN_COLUMNS:  cols_q   <= cfg_wdata_i[dcpf_pkg::COLS_W-1:0];
        dcpf_pkg::REG_DITHER_PATTERNS: dither_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  dcpf_pkg::state_e state_q, state_d;

  logic                          in_beat;
  logic [dcpf_pkg::X_W-1:0]      in_x, x_sat;
  logic [dcpf_pkg::H_W-1:0]      in_h, h_clip;
  logic [FW-1:0]                 full;
  logic [RPW-1:0]                rows_pages;
  logic [PGW-1:0]                pages_in;

  assign in_beat    = s_axis_tvalid && s_axis_tready;
  assign in_x       = s_axis_tdata[dcpf_pkg::X_W-1:0];
  assign in_h       = s_axis_tdata[dcpf_pkg::X_W +: dcpf_pkg::H_W];
  assign full       = FW'(rows_q) << F;
  assign x_sat      = (9'(in_x) >= 9'(MAX_COLUMNS)) ? dcpf_pkg::X_W'(MAX_COLUMNS - 1) : in_x;
  assign h_clip     = (CMPW'(in_h) > CMPW'(full)) ? dcpf_pkg::H_W'(full) : in_h;
  assign rows_pages = rows_q[dcpf_pkg::ROWS_W-1:3];
  assign pages_in   = (RPW'(rows_pages) > RPW'(MAX_PAGES)) ? PGW'(MAX_PAGES) : PGW'(rows_pages);

  // per-column working registers
  logic [dcpf_pkg::H_W-1:0]       h_q;
  logic [PGW-1:0]                 pages_q;
  logic [PGW-1:0]                 page_q;
  logic [dcpf_pkg::ADDR_W-1:0]    addr_q;
  logic [dcpf_pkg::IDX_W-1:0]     phase_q;
  logic [dcpf_pkg::IDX_W-1:0]     rot_q;
  logic [7:0]                     mask_q;
  logic [dcpf_pkg::ROW_IDX_W-1:0] y1_q, y2_q;

  // compare-subtract unit for the dither index
  logic                       div_done;
  logic [dcpf_pkg::IDX_W-1:0] div_quot;

  dcpf_div #(
    .DW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_beat),
    .dividend_i (DW'({h_clip, 3'b000})),
    .divisor_i  (DW'(full) << 2),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // run ends, rounded half up in units of 2^-(F+1)
  logic [YW-1:0] base, y1_t, y2_t;
  logic [dcpf_pkg::ROW_IDX_W-1:0] y1_d, y2_d;

  assign base = YW'(rows_q[dcpf_pkg::ROWS_W-1:1]) << (F + 1);
  assign y1_t = base - YW'(h_q) + (YW'(1) << F);
  assign y2_t = base + YW'(h_q) + (YW'(1) << F);
  assign y1_d = y1_t[YW-1] ? '0 : y1_t[F+1 +: dcpf_pkg::ROW_IDX_W];
  assign y2_d = y2_t[F+1 +: dcpf_pkg::ROW_IDX_W];

  // dither mask
  logic [7:0]  pat;
  logic [15:0] pat_rot;
  assign pat     = dither_q[8*div_quot +: 8];
  assign pat_rot = {pat, pat} >> rot_q;

  // page byte
  logic [7:0] run_byte;
  logic       page_last;
  logic       out_free;

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      run_byte[j] = (dcpf_pkg::ROW_IDX_W'({page_q, 3'(j)}) >= y1_q) &&
                    (dcpf_pkg::ROW_IDX_W'({page_q, 3'(j)}) < y2_q);
    end
  end

  assign page_last = (page_q + PGW'(1)) == pages_q;
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      dcpf_pkg::ST_IDLE: if (in_beat) state_d = dcpf_pkg::ST_DIV;
      dcpf_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = (pages_q == '0) ? dcpf_pkg::ST_IDLE : dcpf_pkg::ST_EMIT;
        end
      end
      dcpf_pkg::ST_EMIT: if (out_free && page_last) state_d = dcpf_pkg::ST_IDLE;
      default: state_d = dcpf_pkg::ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == dcpf_pkg::ST_IDLE);

  logic emit;
  assign emit = (state_q == dcpf_pkg::ST_EMIT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= dcpf_pkg::ST_IDLE;
      phase_q       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_beat) begin
        phase_q <= phase_q + dcpf_pkg::PHASE_STEP;
      end
      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      h_q     <= h_clip;
      pages_q <= pages_in;
      page_q  <= '0;
      addr_q  <= dcpf_pkg::ADDR_W'(x_sat);
      rot_q   <= phase_q;
    end
    if (state_q == dcpf_pkg::ST_DIV) begin
      y1_q <= y1_d;
      y2_q <= y2_d;
      if (div_done) begin
        mask_q <= pat_rot[7:0];
      end
    end
    if (emit) begin
      m_axis_tdata <= {3'b000, run_byte & mask_q, addr_q};
      m_axis_tlast <= page_last;
      page_q       <= page_q + PGW'(1);
      addr_q       <= addr_q + dcpf_pkg::ADDR_W'(cols_q);
    end
  end

endmodule
